FILE: design/pmst_pkg.sv
// Shared types, sizes and codes of the minimum spanning tree engine.
package pmst_pkg;

   // Graph and cost sizes
   localparam int MAX_NODES     = 64;
   localparam int NODE_BITS     = 6;
   localparam int CNT_BITS      = 7;
   localparam int COST_BITS     = 16;
   localparam int SUM_BITS      = 32;
   localparam int MAT_ADDR_BITS = 2 * NODE_BITS;

   // Configuration register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_NODE_COUNT = 1'b0;
   localparam logic [CNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;

   // Input word kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   // Port widths
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 48;

   // One cost matrix entry: presence flag and signed cost
   typedef struct packed {
      logic                 present;
      logic [COST_BITS-1:0] cost;
   } mat_entry_type;

   // Access to the cost matrix memory
   typedef struct packed {
      logic                     wr_en;
      logic [MAT_ADDR_BITS-1:0] wr_addr;
      mat_entry_type            wr_data;
      logic [MAT_ADDR_BITS-1:0] rd_addr;
   } mat_req_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_CMP,
      ST_LOAD_WR,
      ST_RELAX,
      ST_SCAN,
      ST_PICK,
      ST_EMIT_RD,
      ST_EMIT_SUM,
      ST_EMIT_WAIT
   } state_type;

endpackage

FILE: design/pmst_csr.sv
// Configuration register block holding the node count.
module pmst_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pmst_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [pmst_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [pmst_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output logic [pmst_pkg::CNT_BITS-1:0]        node_count
);

   logic [pmst_pkg::CNT_BITS-1:0] node_count_ff;
   logic [pmst_pkg::CNT_BITS-1:0] node_count_in;
   logic                          reg_hit;

   assign reg_hit = (csr_paddr[2] == pmst_pkg::REG_NODE_COUNT);

   // Take a write in the access phase
   always_comb begin
      node_count_in = node_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         node_count_in = csr_pwdata[pmst_pkg::CNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= pmst_pkg::NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   // Return the register on a read, zero elsewhere
   always_comb begin
      csr_prdata = '0;
      if (reg_hit) begin
         csr_prdata = {{(pmst_pkg::CSR_DATA_BITS-pmst_pkg::CNT_BITS){1'b0}}, node_count_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign node_count = node_count_ff;

endmodule

FILE: design/pmst_matrix.sv
// Cost matrix memory: one write port and one registered read port.
module pmst_matrix (
   input  logic                    clock,
   input  pmst_pkg::mat_req_type   mat_req,
   output pmst_pkg::mat_entry_type mat_rdata
);

   localparam int DEPTH = pmst_pkg::MAX_NODES * pmst_pkg::MAX_NODES;

   pmst_pkg::mat_entry_type mem [DEPTH];
   pmst_pkg::mat_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mat_req.wr_en) begin
         mem[mat_req.wr_addr] <= mat_req.wr_data;
      end
      rdata_ff <= mem[mat_req.rd_addr];
   end

   assign mat_rdata = rdata_ff;

endmodule

FILE: design/prim_minimum_spanning_tree.sv
// Top level: edge loading, Prim sequencer, node state and result output.
//
// Usage. Input words arrive on req_*: req_tuser selects the kind (0 loads one
// undirected edge, 1 runs Prim from node 0). req_tdata carries node_a, node_b
// and the signed 16-bit edge cost. An edge load reads the stored entry,
// compares, then writes both directions unless the stored cost is kept or
// the edge is dropped for a bad endpoint or a self loop; it gives no result.
// A run walks the cost matrix one entry per cycle through a single shared
// signed comparator: one relaxation pass from node 0, then per added node
// a scan, a pick and a relaxation pass, for N active nodes. It then gives
// one result per node 1..N-1 on rsp_* (node, parent, running cost sum;
// rsp_tuser flags a disconnected graph; rsp_tlast marks the final result),
// each result offered only once the one before it has been taken. While
// rsp_tvalid is high and rsp_tready low the result holds and the block waits.
// After reset, and after the last result of each run, the cost matrix is
// cleared one entry per cycle, all 4096 entries, with req_tready low. The
// node_count register (csr_*, address 0) may be written at any idle time.
module prim_minimum_spanning_tree (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: node_a[5:0], node_b[11:6], edge_cost[27:12], zero pad
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pmst_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_tuser: kind[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata: tree_node[5:0], parent_node[11:6], total_cost[43:12], zero pad
   output logic [pmst_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // rsp_tuser: disconnected[0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pmst_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pmst_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pmst_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int NB = pmst_pkg::NODE_BITS;
   localparam int CB = pmst_pkg::CNT_BITS;
   localparam int KB = pmst_pkg::COST_BITS;
   localparam int SB = pmst_pkg::SUM_BITS;
   localparam int AB = pmst_pkg::MAT_ADDR_BITS;
   localparam int NN = pmst_pkg::MAX_NODES;

   // Configuration
   logic [CB-1:0] node_count;
   logic [CB-1:0] n_act;
   logic [CB-1:0] n_m1;

   pmst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .node_count  (node_count)
   );

   // Clamp the node count into the supported range
   always_comb begin
      if (node_count < CB'(2)) begin
         n_act = CB'(2);
      end else if (node_count > CB'(NN)) begin
         n_act = CB'(NN);
      end else begin
         n_act = node_count;
      end
   end
   assign n_m1 = n_act - CB'(1);

   // Cost matrix
   pmst_pkg::mat_req_type   mat_req;
   pmst_pkg::mat_entry_type mat_rdata;

   pmst_matrix u_matrix (
      .clock     (clock),
      .mat_req   (mat_req),
      .mat_rdata (mat_rdata)
   );

   // Control registers
   pmst_pkg::state_type state_ff, state_in;
   logic [AB-1:0] clr_addr_ff, clr_addr_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic          stg_vld_ff, stg_vld_in;
   logic [CB-1:0] iter_ff, iter_in;
   logic          best_found_ff, best_found_in;
   logic          fu_found_ff, fu_found_in;
   logic          disc_ff, disc_in;
   logic [NN-1:0] used_ff, used_in;
   logic [NN-1:0] kvalid_ff, kvalid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [NB-1:0] node_a_ff, node_a_in;
   logic [NB-1:0] node_b_ff, node_b_in;
   logic [KB-1:0] cost_ff, cost_in;
   logic [NB-1:0] stg_node_ff, stg_node_in;
   logic [NB-1:0] pick_ff, pick_in;
   logic [NB-1:0] best_node_ff, best_node_in;
   logic [KB-1:0] best_key_ff, best_key_in;
   logic [NB-1:0] fu_node_ff, fu_node_in;
   logic [SB-1:0] sum_ff, sum_in;
   logic [NB-1:0] out_node_ff, out_node_in;
   logic [NB-1:0] out_parent_ff, out_parent_in;
   logic          out_last_ff, out_last_in;

   // Node key and parent memories
   logic [KB-1:0] key_mem [NN];
   logic [NB-1:0] parent_mem [NN];
   logic [KB-1:0] key_rdata_ff;
   logic [NB-1:0] parent_rdata_ff;
   logic [NB-1:0] key_raddr;
   logic          key_we;
   logic [NB-1:0] key_waddr;
   logic [KB-1:0] key_wdata;
   logic [NB-1:0] parent_wdata;

   // Handshake and decode
   logic          req_fire;
   logic          rsp_fire;
   logic          req_kind;
   logic [NB-1:0] req_a;
   logic [NB-1:0] req_b;
   logic [KB-1:0] req_cost;
   logic          load_ok;
   logic          load_upd;
   logic          pass_done;
   logic          st_used;
   logic          st_kv;
   logic          relax_upd;
   logic          scan_better;
   logic          emit_kv;

   // Shared signed comparator
   logic [KB-1:0] cmp_a;
   logic [KB-1:0] cmp_b;
   logic          cmp_lt;

   assign req_tready = (state_ff == pmst_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   assign req_kind = req_tuser;
   assign req_a    = req_tdata[NB-1:0];
   assign req_b    = req_tdata[2*NB-1:NB];
   assign req_cost = req_tdata[2*NB+KB-1:2*NB];

   assign load_ok = ({1'b0, req_a} < n_act) && ({1'b0, req_b} < n_act) && (req_a != req_b);

   assign pass_done = (idx_ff == n_act);
   assign st_used   = used_ff[stg_node_ff];
   assign st_kv     = kvalid_ff[stg_node_ff];
   assign emit_kv   = kvalid_ff[idx_ff[NB-1:0]];

   // Select comparator operands by phase
   always_comb begin
      case (state_ff)
         pmst_pkg::ST_LOAD_CMP: begin
            cmp_a = cost_ff;
            cmp_b = mat_rdata.cost;
         end
         pmst_pkg::ST_RELAX: begin
            cmp_a = mat_rdata.cost;
            cmp_b = key_rdata_ff;
         end
         pmst_pkg::ST_SCAN: begin
            cmp_a = key_rdata_ff;
            cmp_b = best_key_ff;
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end
   assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

   assign load_upd    = !mat_rdata.present || cmp_lt;
   assign relax_upd   = stg_vld_ff && !st_used && mat_rdata.present && (!st_kv || cmp_lt);
   assign scan_better = stg_vld_ff && !st_used && st_kv && (!best_found_ff || cmp_lt);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pmst_pkg::ST_CLEAR: begin
            if (clr_addr_ff == {AB{1'b1}}) begin
               state_in = pmst_pkg::ST_IDLE;
            end
         end
         pmst_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == pmst_pkg::KIND_RUN) begin
                  state_in = pmst_pkg::ST_RELAX;
               end else if (load_ok) begin
                  state_in = pmst_pkg::ST_LOAD_RD;
               end
            end
         end
         pmst_pkg::ST_LOAD_RD: begin
            state_in = pmst_pkg::ST_LOAD_CMP;
         end
         pmst_pkg::ST_LOAD_CMP: begin
            state_in = load_upd ? pmst_pkg::ST_LOAD_WR : pmst_pkg::ST_IDLE;
         end
         pmst_pkg::ST_LOAD_WR: begin
            state_in = pmst_pkg::ST_IDLE;
         end
         pmst_pkg::ST_RELAX: begin
            if (pass_done) begin
               state_in = (iter_ff == n_m1) ? pmst_pkg::ST_EMIT_RD : pmst_pkg::ST_SCAN;
            end
         end
         pmst_pkg::ST_SCAN: begin
            if (pass_done) begin
               state_in = pmst_pkg::ST_PICK;
            end
         end
         pmst_pkg::ST_PICK: begin
            state_in = pmst_pkg::ST_RELAX;
         end
         pmst_pkg::ST_EMIT_RD: begin
            state_in = pmst_pkg::ST_EMIT_SUM;
         end
         pmst_pkg::ST_EMIT_SUM: begin
            state_in = pmst_pkg::ST_EMIT_WAIT;
         end
         pmst_pkg::ST_EMIT_WAIT: begin
            if (rsp_fire) begin
               state_in = out_last_ff ? pmst_pkg::ST_CLEAR : pmst_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = pmst_pkg::ST_CLEAR;
         end
      endcase
   end

   // Datapath control per state
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      idx_in        = idx_ff;
      stg_vld_in    = 1'b0;
      stg_node_in   = idx_ff[NB-1:0];
      iter_in       = iter_ff;
      best_found_in = best_found_ff;
      best_node_in  = best_node_ff;
      best_key_in   = best_key_ff;
      fu_found_in   = fu_found_ff;
      fu_node_in    = fu_node_ff;
      disc_in       = disc_ff;
      used_in       = used_ff;
      kvalid_in     = kvalid_ff;
      rsp_valid_in  = rsp_valid_ff;
      node_a_in     = node_a_ff;
      node_b_in     = node_b_ff;
      cost_in       = cost_ff;
      pick_in       = pick_ff;
      sum_in        = sum_ff;
      out_node_in   = out_node_ff;
      out_parent_in = out_parent_ff;
      out_last_in   = out_last_ff;

      mat_req.wr_en   = 1'b0;
      mat_req.wr_addr = {node_a_ff, node_b_ff};
      mat_req.wr_data = '{present: 1'b1, cost: cost_ff};
      mat_req.rd_addr = {pick_ff, idx_ff[NB-1:0]};

      key_raddr    = idx_ff[NB-1:0];
      key_we       = 1'b0;
      key_waddr    = stg_node_ff;
      key_wdata    = mat_rdata.cost;
      parent_wdata = pick_ff;

      case (state_ff)
         pmst_pkg::ST_CLEAR: begin
            // Sweep the matrix back to no edge, drop node state
            mat_req.wr_en   = 1'b1;
            mat_req.wr_addr = clr_addr_ff;
            mat_req.wr_data = '0;
            clr_addr_in     = clr_addr_ff + AB'(1);
            used_in         = '0;
            kvalid_in       = '0;
         end
         pmst_pkg::ST_IDLE: begin
            node_a_in = req_a;
            node_b_in = req_b;
            cost_in   = req_cost;
            if (req_fire && (req_kind == pmst_pkg::KIND_RUN)) begin
               // Seed the tree with node 0 and relax its row
               pick_in    = '0;
               used_in[0] = 1'b1;
               iter_in    = '0;
               disc_in    = 1'b0;
               sum_in     = '0;
               idx_in     = CB'(1);
            end
         end
         pmst_pkg::ST_LOAD_RD: begin
            mat_req.rd_addr = {node_a_ff, node_b_ff};
         end
         pmst_pkg::ST_LOAD_CMP: begin
            // Keep the cheaper of a parallel edge
            mat_req.wr_en   = load_upd;
            mat_req.wr_addr = {node_a_ff, node_b_ff};
         end
         pmst_pkg::ST_LOAD_WR: begin
            mat_req.wr_en   = 1'b1;
            mat_req.wr_addr = {node_b_ff, node_a_ff};
         end
         pmst_pkg::ST_RELAX: begin
            // Issue one entry of the picked row, lower the key in the next cycle
            if (relax_upd) begin
               key_we                 = 1'b1;
               kvalid_in[stg_node_ff] = 1'b1;
            end
            if (pass_done) begin
               idx_in        = CB'(1);
               best_found_in = 1'b0;
               fu_found_in   = 1'b0;
            end else begin
               stg_vld_in = 1'b1;
               idx_in     = idx_ff + CB'(1);
            end
         end
         pmst_pkg::ST_SCAN: begin
            // Track the least key and the lowest unused node
            if (scan_better) begin
               best_found_in = 1'b1;
               best_node_in  = stg_node_ff;
               best_key_in   = key_rdata_ff;
            end
            if (stg_vld_ff && !st_used && !fu_found_ff) begin
               fu_found_in = 1'b1;
               fu_node_in  = stg_node_ff;
            end
            if (pass_done) begin
               idx_in = CB'(1);
            end else begin
               stg_vld_in = 1'b1;
               idx_in     = idx_ff + CB'(1);
            end
         end
         pmst_pkg::ST_PICK: begin
            // Add the chosen node; fall back to the lowest unused one
            pick_in          = best_found_ff ? best_node_ff : fu_node_ff;
            used_in[pick_in] = 1'b1;
            disc_in          = disc_ff || !best_found_ff;
            iter_in          = iter_ff + CB'(1);
            idx_in           = CB'(1);
         end
         pmst_pkg::ST_EMIT_RD: begin
            key_raddr = idx_ff[NB-1:0];
         end
         pmst_pkg::ST_EMIT_SUM: begin
            // Accumulate the tree edge and load the output word
            if (emit_kv) begin
               sum_in = sum_ff + {{(SB-KB){key_rdata_ff[KB-1]}}, key_rdata_ff};
            end
            out_node_in   = idx_ff[NB-1:0];
            out_parent_in = emit_kv ? parent_rdata_ff : '0;
            out_last_in   = (idx_ff == n_m1);
            rsp_valid_in  = 1'b1;
         end
         pmst_pkg::ST_EMIT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_ff + CB'(1);
               clr_addr_in  = '0;
            end
         end
         default: begin
            clr_addr_in = '0;
         end
      endcase
   end

   // Key and parent memories
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr]    <= key_wdata;
         parent_mem[key_waddr] <= parent_wdata;
      end
      key_rdata_ff    <= key_mem[key_raddr];
      parent_rdata_ff <= parent_mem[key_raddr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pmst_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         idx_ff        <= '0;
         stg_vld_ff    <= 1'b0;
         iter_ff       <= '0;
         best_found_ff <= 1'b0;
         fu_found_ff   <= 1'b0;
         disc_ff       <= 1'b0;
         used_ff       <= '0;
         kvalid_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         idx_ff        <= idx_in;
         stg_vld_ff    <= stg_vld_in;
         iter_ff       <= iter_in;
         best_found_ff <= best_found_in;
         fu_found_ff   <= fu_found_in;
         disc_ff       <= disc_in;
         used_ff       <= used_in;
         kvalid_ff     <= kvalid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      node_a_ff     <= node_a_in;
      node_b_ff     <= node_b_in;
      cost_ff       <= cost_in;
      stg_node_ff   <= stg_node_in;
      pick_ff       <= pick_in;
      best_node_ff  <= best_node_in;
      best_key_ff   <= best_key_in;
      fu_node_ff    <= fu_node_in;
      sum_ff        <= sum_in;
      out_node_ff   <= out_node_in;
      out_parent_ff <= out_parent_in;
      out_last_ff   <= out_last_in;
   end

   // Result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pmst_pkg::RSP_DATA_BITS-2*NB-SB){1'b0}},
                        sum_ff, out_parent_ff, out_node_ff};
   assign rsp_tuser  = disc_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: design/pmst_checker.sv
// Port-level checks for the spanning tree block, bound to the top level.
module pmst_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [pmst_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast
);

   // Hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // Take no input word while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during result output");

   // Start the clearing pass right after reset
   assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("ready during matrix clear after reset");

   // Start the clearing pass after the final result of a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !req_tready)
      else $error("ready right after final result");

   // Never report node 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[pmst_pkg::NODE_BITS-1:0] != '0))
      else $error("result names the root node");

endmodule

bind prim_minimum_spanning_tree pmst_checker u_pmst_checker (.*);

FILE: bench/prim_minimum_spanning_tree_test.sv
// Testbench for the minimum spanning tree engine: directed table, then random graphs.
`timescale 1ns / 100ps

module prim_minimum_spanning_tree_test;

   localparam int CLEAR_WAIT = pmst_pkg::MAX_NODES * pmst_pkg::MAX_NODES + 64;
   localparam logic [pmst_pkg::CSR_ADDR_BITS-1:0] NODE_COUNT_ADDR =
      {pmst_pkg::REG_NODE_COUNT, 2'b00};

   // Kinds of rows in the directed table
   typedef enum bit [1:0] {STEP_CONFIG, STEP_LOAD, STEP_RUN} step_kind_type;

   typedef struct packed {
      step_kind_type step;
      int            a;           // node_a, or the register value on a config row
      int            b;
      int            cost;
      bit            typed;       // one-result run whose outcome is written in the row
      int            want_total;
      bit            want_disc;
   } plan_row_type;

   // One result word of a run
   typedef struct packed {
      logic [pmst_pkg::NODE_BITS-1:0] node;
      logic [pmst_pkg::NODE_BITS-1:0] parent;
      logic [pmst_pkg::SUM_BITS-1:0]  total;
      logic                           disc;
      logic                           last;
   } tree_word_type;

   localparam int PLAN_ROWS = 29;
   plan_row_type plan [PLAN_ROWS] = '{
      '{STEP_RUN,    63, 63,     -1, 1'b0,      0, 1'b0},  // empty matrix after reset
      '{STEP_CONFIG,  2,  0,      0, 1'b0,      0, 1'b0},
      '{STEP_LOAD,    0,  1, -32768, 1'b0,      0, 1'b0},
      '{STEP_RUN,     0,  0,      0, 1'b1, -32768, 1'b0},
      '{STEP_LOAD,    1,  0,  32767, 1'b0,      0, 1'b0},
      '{STEP_LOAD,    0,  1,      5, 1'b0,      0, 1'b0},  // parallel edge, lower cost wins
      '{STEP_LOAD,    1,  1,     -7, 1'b0,      0, 1'b0},  // self loop
      '{STEP_LOAD,    0,  2,   -100, 1'b0,      0, 1'b0},  // endpoint beyond node count
      '{STEP_LOAD,   63,  1,   -200, 1'b0,      0, 1'b0},
      '{STEP_RUN,    42, 21,  32767, 1'b1,      5, 1'b0},
      '{STEP_RUN,     0,  0,      0, 1'b1,      0, 1'b1},  // no edge: node 1 unreachable
      '{STEP_CONFIG,  0,  0,      0, 1'b0,      0, 1'b0},  // below range acts as 2
      '{STEP_LOAD,    1,  0,     -1, 1'b0,      0, 1'b0},
      '{STEP_RUN,     0,  0,      0, 1'b1,     -1, 1'b0},
      '{STEP_CONFIG,  1,  0,      0, 1'b0,      0, 1'b0},
      '{STEP_LOAD,    0,  1,      0, 1'b0,      0, 1'b0},
      '{STEP_RUN,    21, 42, -32768, 1'b1,      0, 1'b0},
      '{STEP_CONFIG, 127, 0,      0, 1'b0,      0, 1'b0},  // above range acts as 64
      '{STEP_LOAD,   63, 62,  32767, 1'b0,      0, 1'b0},
      '{STEP_LOAD,    0, 63, -32768, 1'b0,      0, 1'b0},
      '{STEP_LOAD,   62,  0,  32767, 1'b0,      0, 1'b0},  // equal key keeps first parent
      '{STEP_RUN,     0,  0,      0, 1'b0,      0, 1'b0},
      '{STEP_CONFIG,  4,  0,      0, 1'b0,      0, 1'b0},
      '{STEP_LOAD,    0,  1,      3, 1'b0,      0, 1'b0},  // equal costs: lowest index first
      '{STEP_LOAD,    0,  2,      3, 1'b0,      0, 1'b0},
      '{STEP_LOAD,    1,  3,      3, 1'b0,      0, 1'b0},
      '{STEP_LOAD,    2,  3,      3, 1'b0,      0, 1'b0},
      '{STEP_LOAD,    1,  2,     -2, 1'b0,      0, 1'b0},
      '{STEP_RUN,     0,  0,      0, 1'b0,      0, 1'b0}
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [pmst_pkg::REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [pmst_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tlast;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [pmst_pkg::CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [pmst_pkg::CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [pmst_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                                csr_pready;

   // Predicted engine state
   bit                                    link_on   [pmst_pkg::MAX_NODES][pmst_pkg::MAX_NODES];
   logic signed [pmst_pkg::COST_BITS-1:0] link_cost [pmst_pkg::MAX_NODES][pmst_pkg::MAX_NODES];
   logic [pmst_pkg::CNT_BITS-1:0]         node_count_setting = pmst_pkg::NODE_COUNT_RESET;

   tree_word_type tree_scratch [$];
   tree_word_type tree_due [$];
   int            mismatches = 0;
   int            words_sent = 0;
   bit            req_quiet = 1'b0;
   bit            rsp_quiet = 1'b0;
   int            rsp_hold = 0;

   prim_minimum_spanning_tree dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   task automatic flag_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Idle draw shared by both sides, with stretches of no idling
   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 11) == 0) begin
         quiet = !quiet;
      end
      return quiet ? 0 : int'($urandom_range(0, 14));
   endfunction

   function automatic int active_count();
      if (node_count_setting < 2) begin
         return 2;
      end
      if (node_count_setting > pmst_pkg::MAX_NODES) begin
         return pmst_pkg::MAX_NODES;
      end
      return int'(node_count_setting);
   endfunction

   function automatic void clear_links();
      for (int u = 0; u < pmst_pkg::MAX_NODES; u++) begin
         for (int v = 0; v < pmst_pkg::MAX_NODES; v++) begin
            link_on[u][v]   = 1'b0;
            link_cost[u][v] = '0;
         end
      end
   endfunction

   // Store one undirected edge, keeping the cheaper of parallel edges
   function automatic void add_edge(input int a, input int b,
                                    input logic signed [pmst_pkg::COST_BITS-1:0] cost);
      int n;
      n = active_count();
      if (a < n && b < n && a != b) begin
         if (!link_on[a][b] || cost < link_cost[a][b]) begin
            link_on[a][b]   = 1'b1;
            link_cost[a][b] = cost;
            link_on[b][a]   = 1'b1;
            link_cost[b][a] = cost;
         end
      end
   endfunction

   // Grow the tree from node 0 into tree_scratch, then clear the edge store
   function automatic void grow_tree();
      int                                    n;
      int                                    pick;
      bit                                    used   [pmst_pkg::MAX_NODES];
      bit                                    key_on [pmst_pkg::MAX_NODES];
      logic signed [pmst_pkg::COST_BITS-1:0] key    [pmst_pkg::MAX_NODES];
      int                                    parent [pmst_pkg::MAX_NODES];
      bit                                    broken;
      logic [pmst_pkg::SUM_BITS-1:0]         sum;
      tree_word_type                         w;
      n = active_count();
      broken = 1'b0;
      sum = '0;
      tree_scratch.delete();
      for (int v = 0; v < pmst_pkg::MAX_NODES; v++) begin
         used[v]   = 1'b0;
         key_on[v] = 1'b0;
         key[v]    = '0;
         parent[v] = 0;
      end
      used[0] = 1'b1;
      for (int v = 1; v < n; v++) begin
         if (link_on[0][v]) begin
            key_on[v] = 1'b1;
            key[v]    = link_cost[0][v];
         end
      end
      for (int step = 1; step < n; step++) begin
         // take the cheapest reachable node, lowest index on a tie
         pick = n;
         for (int v = 1; v < n; v++) begin
            if (!used[v] && key_on[v] && (pick == n || key[v] < key[pick])) begin
               pick = v;
            end
         end
         // nothing reachable: take the lowest unused node
         if (pick == n) begin
            broken = 1'b1;
            for (int v = 1; v < n; v++) begin
               if (!used[v] && pick == n) begin
                  pick = v;
               end
            end
         end
         used[pick] = 1'b1;
         for (int v = 1; v < n; v++) begin
            if (!used[v] && link_on[pick][v] &&
                (!key_on[v] || link_cost[pick][v] < key[v])) begin
               key_on[v] = 1'b1;
               key[v]    = link_cost[pick][v];
               parent[v] = pick;
            end
         end
      end
      for (int i = 1; i < n; i++) begin
         w.parent = '0;
         if (key_on[i]) begin
            sum = sum + {{(pmst_pkg::SUM_BITS - pmst_pkg::COST_BITS)
                          {key[i][pmst_pkg::COST_BITS-1]}}, key[i]};
            w.parent = pmst_pkg::NODE_BITS'(parent[i]);
         end
         w.node  = pmst_pkg::NODE_BITS'(i);
         w.total = sum;
         w.disc  = broken;
         w.last  = (i + 1 == n);
         tree_scratch = {tree_scratch, w};
      end
      clear_links();
   endfunction

   // Present one word and hold it until the engine takes it
   task automatic send_word(input logic kind, input int a, input int b, input int cost);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, 16'(cost), 6'(b), 6'(a)};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic post_word(input logic kind, input int a, input int b, input int cost);
      send_word(kind, a, b, cost);
      if (kind == pmst_pkg::KIND_LOAD) begin
         add_edge(a, b, 16'(cost));
      end else begin
         grow_tree();
         tree_due = {tree_due, tree_scratch};
      end
   endtask

   // Write node_count once the engine is idle and its clearing pass is over
   task automatic set_node_count(input int value);
      req_tvalid <= 1'b0;
      while (tree_due.size() != 0) @(posedge clock);
      repeat (CLEAR_WAIT) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= NODE_COUNT_ADDR;
      csr_pwdata  <= pmst_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      node_count_setting = pmst_pkg::CNT_BITS'(value);
   endtask

   function automatic int pick_cost();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2, 3, 4: return int'($urandom_range(0, 6)) - 3;   // narrow range forces ties
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Load one random graph on n nodes, with some junk words, then run it
   task automatic send_graph(input int n);
      int ends_a [$];
      int ends_b [$];
      int order [$];
      int j;
      int t;
      int u;
      int v;
      int extra;
      bit linked;
      linked = ($urandom_range(0, 9) < 7);
      if (linked) begin
         for (int k = 1; k < n; k++) begin
            order = {order, k};
         end
         for (int k = order.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
         end
         // random spanning tree so that every node is reachable
         for (int k = 0; k < order.size(); k++) begin
            u = order[k];
            v = (k == 0 || $urandom_range(0, 3) == 0) ? 0 : order[$urandom_range(0, k - 1)];
            if ($urandom_range(0, 1) == 0) begin
               ends_a = {ends_a, u};
               ends_b = {ends_b, v};
            end else begin
               ends_a = {ends_a, v};
               ends_b = {ends_b, u};
            end
         end
      end
      extra = linked ? $urandom_range(0, n / 4 + 2) : $urandom_range(0, n);
      repeat (extra) begin
         u = $urandom_range(0, n - 1);
         v = (u + $urandom_range(1, n - 1)) % n;
         ends_a = {ends_a, u};
         ends_b = {ends_b, v};
      end
      for (int k = ends_a.size() - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = ends_a[k];
         ends_a[k] = ends_a[j];
         ends_a[j] = t;
         t = ends_b[k];
         ends_b[k] = ends_b[j];
         ends_b[j] = t;
      end
      for (int k = 0; k < ends_a.size(); k++) begin
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  u = $urandom_range(0, 63);
                  post_word(pmst_pkg::KIND_LOAD, u, u, pick_cost());
               end
               1: begin
                  if (n < pmst_pkg::MAX_NODES) begin
                     post_word(pmst_pkg::KIND_LOAD, $urandom_range(n, 63),
                               $urandom_range(0, 63), pick_cost());
                  end else begin
                     post_word(pmst_pkg::KIND_LOAD, ends_b[k], ends_a[k], pick_cost());
                  end
               end
               default: begin
                  // repeat an earlier or the current edge reversed
                  j = $urandom_range(0, k);
                  post_word(pmst_pkg::KIND_LOAD, ends_b[j], ends_a[j], pick_cost());
               end
            endcase
         end
         post_word(pmst_pkg::KIND_LOAD, ends_a[k], ends_b[k], pick_cost());
      end
      post_word(pmst_pkg::KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                pick_cost());
   endtask

   // Result side: random stalls, check each word against the oldest prediction
   always @(posedge clock) begin
      tree_word_type due_word;
      if (reset) begin
         rsp_hold = draw_wait(rsp_quiet);
         rsp_tready <= (rsp_hold == 0);
      end else if (rsp_tvalid && rsp_tready) begin
         if (tree_due.size() == 0) begin
            flag_mismatch($sformatf("result for node %0d with none due", rsp_tdata[5:0]));
         end else begin
            due_word = tree_due.pop_front();
            if (rsp_tdata[5:0] !== due_word.node) begin
               flag_mismatch($sformatf("tree_node %0d, want %0d",
                                       rsp_tdata[5:0], due_word.node));
            end
            if (rsp_tdata[11:6] !== due_word.parent) begin
               flag_mismatch($sformatf("node %0d parent %0d, want %0d",
                                       due_word.node, rsp_tdata[11:6], due_word.parent));
            end
            if (rsp_tdata[43:12] !== due_word.total) begin
               flag_mismatch($sformatf("node %0d total %0d, want %0d", due_word.node,
                                       $signed(rsp_tdata[43:12]), $signed(due_word.total)));
            end
            if (rsp_tuser !== due_word.disc) begin
               flag_mismatch($sformatf("node %0d disconnected %b, want %b",
                                       due_word.node, rsp_tuser, due_word.disc));
            end
            if (rsp_tlast !== due_word.last) begin
               flag_mismatch($sformatf("node %0d last %b, want %b",
                                       due_word.node, rsp_tlast, due_word.last));
            end
         end
         rsp_hold = draw_wait(rsp_quiet);
         rsp_tready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // Stimulus: reset, directed table, random phases, drain
   initial begin
      tree_word_type typed_word;
      int            setting;
      int            graphs;
      int            phase;
      clear_links();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         case (plan[r].step)
            STEP_CONFIG: begin
               set_node_count(plan[r].a);
            end
            STEP_LOAD: begin
               post_word(pmst_pkg::KIND_LOAD, plan[r].a, plan[r].b, plan[r].cost);
            end
            default: begin
               if (!plan[r].typed) begin
                  post_word(pmst_pkg::KIND_RUN, plan[r].a, plan[r].b, plan[r].cost);
               end else begin
                  // two-node run: node 1 hangs off node 0
                  send_word(pmst_pkg::KIND_RUN, plan[r].a, plan[r].b, plan[r].cost);
                  grow_tree();
                  typed_word.node   = pmst_pkg::NODE_BITS'(1);
                  typed_word.parent = '0;
                  typed_word.total  = pmst_pkg::SUM_BITS'(plan[r].want_total);
                  typed_word.disc   = plan[r].want_disc;
                  typed_word.last   = 1'b1;
                  tree_due = {tree_due, typed_word};
               end
            end
         endcase
      end

      // full size first, then out of range above, then mostly small graphs
      for (phase = 0; words_sent < 205; phase++) begin
         case (phase)
            0: setting = pmst_pkg::MAX_NODES;
            1: setting = $urandom_range(pmst_pkg::MAX_NODES + 1, 127);
            default: begin
               case ($urandom_range(0, 7))
                  0: setting = $urandom_range(0, 1);
                  1: setting = $urandom_range(13, 40);
                  default: setting = $urandom_range(2, 12);
               endcase
            end
         endcase
         set_node_count(setting);
         graphs = (phase < 2) ? 1 : $urandom_range(1, 3);
         repeat (graphs) send_graph(active_count());
      end

      req_tvalid <= 1'b0;
      while (tree_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #400_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: files.f
design/pmst_pkg.sv
design/pmst_csr.sv
design/pmst_matrix.sv
design/prim_minimum_spanning_tree.sv
design/pmst_checker.sv
bench/prim_minimum_spanning_tree_test.sv
